// ----- rtl/hcfh_pkg.sv -----
// Package with the transaction types and constants of the Huffman code builder.
package hcfh_pkg;

   localparam int unsigned GRAY_WIDTH = 8;
   localparam int unsigned LEN_WIDTH = 7;
   localparam int unsigned CODE_WIDTH = 64;
   localparam int unsigned TOTAL_WIDTH = 24;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [GRAY_WIDTH-1:0] value;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic                   status;
      logic                   present;
      logic [GRAY_WIDTH-1:0]  gray_level;
      logic [LEN_WIDTH-1:0]   code_length;
      logic [CODE_WIDTH-1:0]  code_bits;
      logic [GRAY_WIDTH-1:0]  symbol_count;
      logic [TOTAL_WIDTH-1:0] pixel_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_CODE_START,
      ST_CODE_WALK,
      ST_CODE_STORE,
      ST_QUERY_RD,
      ST_QUERY_OUT,
      ST_RESULT,
      ST_CLEAR
   } state_type;

endpackage

// ----- rtl/hcfh_queue.sv -----
// Two-entry transaction queue between the front part and the engine.
module hcfh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  hcfh_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_take,
   output hcfh_pkg::req_type out_data
);

   hcfh_pkg::req_type slot_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       rd_ff;
   logic       wr_ff;
   logic       push;
   logic       pop;

   assign in_stall = (count_ff == 2'd2);
   assign push = in_valid && !in_stall;
   assign out_valid = (count_ff != 2'd0);
   assign pop = out_take && out_valid;
   assign out_data = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

endmodule

// ----- rtl/hcfh_engine.sv -----
// Engine that counts pixels, builds the code and answers queries.
module hcfh_engine #(
   parameter int unsigned LEVELS = 256,
   parameter int unsigned COUNT_WIDTH = 24,
   parameter int unsigned MAX_CODE_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  hcfh_pkg::req_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcfh_pkg::rsp_type rsp_data
);

   localparam int unsigned LW = $clog2(LEVELS);
   localparam int unsigned WW = COUNT_WIDTH + LW;
   localparam int unsigned MW = 2 * LW;
   localparam int unsigned CW = $clog2(MAX_CODE_BITS + 1);
   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
   localparam logic [CW-1:0] LEN_MAX = CW'(MAX_CODE_BITS);
   localparam logic [MAX_CODE_BITS-1:0] BIT0 = MAX_CODE_BITS'(1);

   logic [COUNT_WIDTH-1:0]   counts_mem [LEVELS];
   logic [WW-1:0]            weight_mem [LEVELS];
   logic [MW-1:0]            log_mem [LEVELS];
   logic [MAX_CODE_BITS-1:0] word_mem [LEVELS];
   logic [CW-1:0]            len_mem [LEVELS];

   hcfh_pkg::state_type state_ff, state_in;
   logic [LW:0]            idx_ff, idx_in;
   logic [LW:0]            rnd_ff, rnd_in;
   logic [LW:0]            nsym_ff, nsym_in;
   logic [LW-1:0]          cur_ff, cur_in;
   logic [LW-1:0]          a_ff, a_in;
   logic [LW-1:0]          b_ff, b_in;
   logic [WW-1:0]          w1_ff, w1_in;
   logic [WW-1:0]          w2_ff, w2_in;
   logic                   h1_ff, h1_in;
   logic                   h2_ff, h2_in;
   logic [CW-1:0]          len_ff, len_in;
   logic [MAX_CODE_BITS-1:0] bits_ff, bits_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic                   sat_ff, sat_in;
   logic                   built_ff, built_in;
   logic                   valid_ff, valid_in;
   hcfh_pkg::rsp_type      rsp_ff, rsp_in;

   logic [COUNT_WIDTH-1:0] cnt_rd_ff;
   logic [WW-1:0]          wa_rd_ff;
   logic [MW-1:0]          log_rd_ff;
   logic [MAX_CODE_BITS-1:0] word_rd_ff;
   logic [CW-1:0]          len_rd_ff;

   logic                   cnt_we;
   logic [LW-1:0]          cnt_wa;
   logic [COUNT_WIDTH-1:0] cnt_wd;
   logic [LW-1:0]          cnt_ra;
   logic                   w_we;
   logic [LW-1:0]          w_wa;
   logic [WW-1:0]          w_wd;
   logic [LW-1:0]          w_ra;
   logic                   log_we;
   logic [LW-1:0]          log_ra;
   logic                   code_we;
   logic [LW-1:0]          code_a;

   logic [LW-1:0]          idx_lo;
   logic                   in_range;
   logic [LW-1:0]          val_ix;
   logic [MW-1:0]          log_wd;

   assign idx_lo = idx_ff[LW-1:0];
   assign val_ix = LW'(cmd_data.value);
   assign in_range = (cmd_data.value != '0) && ({24'd0, cmd_data.value} < 32'(LEVELS));
   assign log_wd = {a_ff, b_ff};
   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         counts_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= counts_mem[cnt_ra];
      if (w_we) begin
         weight_mem[w_wa] <= w_wd;
      end
      wa_rd_ff <= weight_mem[w_ra];
      if (log_we) begin
         log_mem[rnd_ff[LW-1:0]] <= log_wd;
      end
      log_rd_ff <= log_mem[log_ra];
      if (code_we) begin
         word_mem[code_a] <= bits_ff;
         len_mem[code_a] <= len_ff;
      end
      word_rd_ff <= word_mem[code_a];
      len_rd_ff <= len_mem[code_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcfh_pkg::ST_CLEAR;
         idx_ff <= '0;
         total_ff <= '0;
         sat_ff <= 1'b0;
         built_ff <= 1'b0;
         valid_ff <= 1'b0;
         nsym_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         total_ff <= total_in;
         sat_ff <= sat_in;
         built_ff <= built_in;
         valid_ff <= valid_in;
         nsym_ff <= nsym_in;
      end
      rnd_ff <= rnd_in;
      cur_ff <= cur_in;
      a_ff <= a_in;
      b_ff <= b_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      h1_ff <= h1_in;
      h2_ff <= h2_in;
      len_ff <= len_in;
      bits_ff <= bits_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      logic [WW-1:0] w;
      logic [LW-1:0] lv;
      logic [LW-1:0] fa;
      logic [LW-1:0] kb;
      w = '0;
      lv = '0;
      fa = log_rd_ff[MW-1:LW];
      kb = log_rd_ff[LW-1:0];
      state_in = state_ff;
      idx_in = idx_ff;
      rnd_in = rnd_ff;
      nsym_in = nsym_ff;
      cur_in = cur_ff;
      a_in = a_ff;
      b_in = b_ff;
      w1_in = w1_ff;
      w2_in = w2_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      len_in = len_ff;
      bits_in = bits_ff;
      total_in = total_ff;
      sat_in = sat_ff;
      built_in = built_ff;
      valid_in = valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      cmd_take = 1'b0;
      cnt_we = 1'b0;
      cnt_wa = idx_lo;
      cnt_wd = '0;
      cnt_ra = val_ix;
      w_we = 1'b0;
      w_wa = idx_lo;
      w_wd = WW'(cnt_rd_ff);
      w_ra = idx_lo;
      log_we = 1'b0;
      log_ra = rnd_ff[LW-1:0];
      code_we = 1'b0;
      code_a = val_ix;
      unique case (state_ff)
         hcfh_pkg::ST_CLEAR: begin
            cnt_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (LW+1)'(LEVELS - 1)) begin
               idx_in = '0;
               state_in = hcfh_pkg::ST_IDLE;
            end
         end
         hcfh_pkg::ST_IDLE: begin
            if (cmd_valid && !valid_ff) begin
               if (cmd_data.kind == hcfh_pkg::KIND_PIXEL && built_ff) begin
                  built_in = 1'b0;
                  nsym_in = '0;
                  total_in = '0;
                  sat_in = 1'b0;
                  idx_in = '0;
                  state_in = hcfh_pkg::ST_CLEAR;
               end else begin
                  state_in = hcfh_pkg::ST_QUERY_RD;
               end
            end
         end
         hcfh_pkg::ST_QUERY_RD: begin
            state_in = hcfh_pkg::ST_QUERY_OUT;
         end
         hcfh_pkg::ST_QUERY_OUT: begin
            cmd_take = 1'b1;
            rsp_in.status = sat_ff;
            rsp_in.present = 1'b0;
            rsp_in.gray_level = cmd_data.value;
            rsp_in.code_length = '0;
            rsp_in.code_bits = '0;
            rsp_in.symbol_count = built_ff ? 8'(nsym_ff) : 8'd0;
            rsp_in.pixel_total = 24'(total_ff);
            state_in = hcfh_pkg::ST_IDLE;
            if (cmd_data.kind == hcfh_pkg::KIND_PIXEL) begin
               if (in_range) begin
                  cnt_we = 1'b1;
                  cnt_wa = val_ix;
                  cnt_wd = (cnt_rd_ff == CMAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
                  if (total_ff == CMAX) begin
                     sat_in = 1'b1;
                  end else begin
                     total_in = total_ff + 1'b1;
                  end
               end
               if (cmd_data.last) begin
                  idx_in = '0;
                  nsym_in = '0;
                  state_in = hcfh_pkg::ST_INIT;
               end
            end else begin
               valid_in = 1'b1;
               if (built_ff && in_range && cnt_rd_ff != '0) begin
                  rsp_in.present = 1'b1;
                  rsp_in.code_length = 7'(len_rd_ff);
                  rsp_in.code_bits = 64'(word_rd_ff);
               end
            end
         end
         hcfh_pkg::ST_INIT: begin
            cnt_ra = idx_lo;
            idx_in = idx_ff + 1'b1;
            if (idx_ff != '0) begin
               w_we = 1'b1;
               w_wa = LW'(idx_ff - 1'b1);
               w_wd = WW'(cnt_rd_ff);
               if (cnt_rd_ff != '0) begin
                  nsym_in = nsym_ff + 1'b1;
               end
            end
            if (idx_ff == (LW+1)'(LEVELS)) begin
               idx_in = '0;
               rnd_in = '0;
               h1_in = 1'b0;
               h2_in = 1'b0;
               if (nsym_in > (LW+1)'(1)) begin
                  state_in = hcfh_pkg::ST_SCAN;
               end else begin
                  state_in = hcfh_pkg::ST_CODE_START;
               end
            end
         end
         hcfh_pkg::ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff != '0) begin
               w = wa_rd_ff;
               lv = LW'(idx_ff - 1'b1);
               if (w != '0) begin
                  if (!h1_ff || w < w1_ff) begin
                     if (h1_ff) begin
                        w2_in = w1_ff;
                        b_in = a_ff;
                        h2_in = 1'b1;
                     end
                     w1_in = w;
                     a_in = lv;
                     h1_in = 1'b1;
                  end else if (!h2_ff || w < w2_ff) begin
                     w2_in = w;
                     b_in = lv;
                     h2_in = 1'b1;
                  end
               end
            end
            if (idx_ff == (LW+1)'(LEVELS)) begin
               idx_in = '0;
               state_in = hcfh_pkg::ST_MERGE_RD;
            end
         end
         hcfh_pkg::ST_MERGE_RD: begin
            w_we = 1'b1;
            w_wa = a_ff;
            w_wd = '0;
            log_we = 1'b1;
            state_in = hcfh_pkg::ST_MERGE_WR;
         end
         hcfh_pkg::ST_MERGE_WR: begin
            w_we = 1'b1;
            w_wa = b_ff;
            w_wd = w1_ff + w2_ff;
            rnd_in = rnd_ff + 1'b1;
            h1_in = 1'b0;
            h2_in = 1'b0;
            idx_in = '0;
            if (rnd_ff + 2'd2 == nsym_ff) begin
               state_in = hcfh_pkg::ST_CODE_START;
            end else begin
               state_in = hcfh_pkg::ST_SCAN;
            end
         end
         hcfh_pkg::ST_CODE_START: begin
            cnt_ra = idx_lo;
            log_ra = '0;
            rnd_in = '0;
            cur_in = idx_lo;
            len_in = '0;
            bits_in = '0;
            state_in = hcfh_pkg::ST_CODE_WALK;
         end
         hcfh_pkg::ST_CODE_WALK: begin
            cnt_ra = idx_lo;
            log_ra = LW'(rnd_ff + 1'b1);
            if (cnt_rd_ff == '0) begin
               if (idx_ff == (LW+1)'(LEVELS - 1)) begin
                  state_in = hcfh_pkg::ST_RESULT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = hcfh_pkg::ST_CODE_START;
               end
            end else if (rnd_ff + 1'b1 == nsym_ff) begin
               state_in = hcfh_pkg::ST_CODE_STORE;
            end else begin
               rnd_in = rnd_ff + 1'b1;
               if (kb == cur_ff) begin
                  if (len_ff < LEN_MAX) begin
                     len_in = len_ff + 1'b1;
                  end
               end else if (fa == cur_ff) begin
                  if (len_ff < LEN_MAX) begin
                     bits_in = bits_ff | (BIT0 << len_ff);
                     len_in = len_ff + 1'b1;
                  end
                  cur_in = kb;
               end
            end
         end
         hcfh_pkg::ST_CODE_STORE: begin
            code_we = 1'b1;
            code_a = idx_lo;
            if (idx_ff == (LW+1)'(LEVELS - 1)) begin
               state_in = hcfh_pkg::ST_RESULT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = hcfh_pkg::ST_CODE_START;
            end
         end
         hcfh_pkg::ST_RESULT: begin
            rsp_in.status = sat_ff;
            rsp_in.present = 1'b0;
            rsp_in.code_length = '0;
            rsp_in.code_bits = '0;
            rsp_in.symbol_count = 8'(nsym_ff);
            rsp_in.pixel_total = 24'(total_ff);
            valid_in = 1'b1;
            built_in = 1'b1;
            idx_in = '0;
            state_in = hcfh_pkg::ST_IDLE;
         end
         default: begin
            state_in = hcfh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/huffman_code_from_histogram.sv -----
// Top level of the Huffman code builder over a gray-level histogram.
//  channel | direction | payload
//  req     | in        | hcfh_pkg::req_type
//  rsp     | out       | hcfh_pkg::rsp_type
// A pixel or a query goes from ST_IDLE through ST_QUERY_RD to ST_QUERY_OUT, where it leaves the
// queue; the result of a query then waits in the output register.
// A last pixel starts a build: ST_INIT loads the weights, each merge round runs ST_SCAN,
// ST_MERGE_RD and ST_MERGE_WR, then ST_CODE_START and ST_CODE_WALK visit each level, with
// ST_CODE_STORE for a present level, and ST_RESULT posts the result.
// After reset, and before the first pixel of each new image, a pass clears all LEVELS counters.
// A waiting result on rsp holds the engine; the two-entry queue takes requests until it is full.
module huffman_code_from_histogram #(
   parameter int unsigned LEVELS = 256,
   parameter int unsigned COUNT_WIDTH = 24,
   parameter int unsigned MAX_CODE_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcfh_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcfh_pkg::rsp_type rsp_data
);

   logic              q_valid;
   logic              q_take;
   hcfh_pkg::req_type q_data;

   hcfh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_take  (q_take),
      .out_data  (q_data)
   );

   hcfh_engine #(
      .LEVELS        (LEVELS),
      .COUNT_WIDTH   (COUNT_WIDTH),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_take  (q_take),
      .cmd_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("engine took from an empty queue");

endmodule
